[hw/rtl/mbps_pkg.sv]
// Shared types and constants for the masked byte pattern scanner.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package mbps_pkg;

	// Field widths fixed by the register map and the item format.
	localparam int BYTE_W        = 8;
	localparam int ADDR_W        = 64;
	localparam int COUNT_W       = 32;
	localparam int LEN_W         = 5;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int PATTERN_BYTES = 16;
	localparam int PATTERN_W     = PATTERN_BYTES * BYTE_W;

	// Register reset values.
	localparam logic [PATTERN_BYTES-1:0] CARE_RESET = 16'hFFFF;
	localparam logic [LEN_W-1:0]         LEN_RESET  = 5'd1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_CARE_MASK    = 3'd2,
		REG_PATTERN_LEN  = 3'd3,
		REG_RESULT_LIMIT = 3'd4,
		REG_FIRST_ONLY   = 3'd5
	} cfg_reg_t;

	// Current register contents as seen by the datapath.
	typedef struct packed {
		logic [PATTERN_W-1:0]     pattern;
		logic [PATTERN_BYTES-1:0] care_mask;
		logic [LEN_W-1:0]         pattern_length;
		logic [COUNT_W-1:0]       result_limit;
		logic                     first_match_only;
	} cfg_t;

	// Compare outcome handed from the matcher to the result stage.
	typedef struct packed {
		logic             hit;
		logic [LEN_W-1:0] len_m1;
	} match_t;

endpackage

[hw/rtl/mbps_cfg_regs.sv]
// Configuration register file for the masked byte pattern scanner.
// Depends on mbps_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module mbps_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_data,
	output mbps_pkg::cfg_t                     cfg
);

	mbps_pkg::cfg_t cfg_q;

	// Writes are never held off, so the port is always ready.
	assign cfg_ready = 1'b1;

	// Register writes; indexes beyond the map are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern          <= '0;
			cfg_q.care_mask        <= mbps_pkg::CARE_RESET;
			cfg_q.pattern_length   <= mbps_pkg::LEN_RESET;
			cfg_q.result_limit     <= '0;
			cfg_q.first_match_only <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mbps_pkg::REG_PATTERN_LOW: begin
					cfg_q.pattern[mbps_pkg::CFG_DATA_W-1:0] <= cfg_data;
				end
				mbps_pkg::REG_PATTERN_HIGH: begin
					cfg_q.pattern[mbps_pkg::PATTERN_W-1:mbps_pkg::CFG_DATA_W] <= cfg_data;
				end
				mbps_pkg::REG_CARE_MASK: begin
					cfg_q.care_mask <= cfg_data[mbps_pkg::PATTERN_BYTES-1:0];
				end
				mbps_pkg::REG_PATTERN_LEN: begin
					cfg_q.pattern_length <= cfg_data[mbps_pkg::LEN_W-1:0];
				end
				mbps_pkg::REG_RESULT_LIMIT: begin
					cfg_q.result_limit <= cfg_data[mbps_pkg::COUNT_W-1:0];
				end
				mbps_pkg::REG_FIRST_ONLY: begin
					cfg_q.first_match_only <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/mbps_window.sv]
// Sliding byte window and fill counter for the masked byte pattern scanner.
// Depends on mbps_pkg for the byte width.
`timescale 1ns / 1ps

module mbps_window #(
	parameter int  PATTERN_MAX = 16,
	localparam int FILL_W      = $clog2(PATTERN_MAX + 1)
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        shift_en,
	input  logic                                        restart,
	input  logic [mbps_pkg::BYTE_W-1:0]                 data_byte,
	output logic [PATTERN_MAX-1:0][mbps_pkg::BYTE_W-1:0] window,
	output logic [FILL_W-1:0]                           fill
);

	logic [PATTERN_MAX-1:0][mbps_pkg::BYTE_W-1:0] win_q;
	logic [FILL_W-1:0]                           fill_q;

	// Entry 0 holds the newest byte; older bytes move up by one.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q[0] <= data_byte;
			for (int j = PATTERN_MAX - 1; j > 0; j--) begin
				win_q[j] <= win_q[j-1];
			end
		end
	end

	// Count of valid bytes, saturating at the window depth. A restart byte
	// opens a new region and is its first valid byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (shift_en) begin
			if (restart) begin
				fill_q <= FILL_W'(1);
			end else if (fill_q != FILL_W'(PATTERN_MAX)) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	assign window = win_q;
	assign fill   = fill_q;

endmodule

[hw/rtl/mbps_match.sv]
// Parallel masked compare of the byte window against the pattern.
// Depends on mbps_pkg for cfg_t, match_t and the field widths.
`timescale 1ns / 1ps

module mbps_match #(
	parameter int  PATTERN_MAX = 16,
	localparam int FILL_W      = $clog2(PATTERN_MAX + 1),
	localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
	input  logic [PATTERN_MAX-1:0][mbps_pkg::BYTE_W-1:0] window,
	input  logic [FILL_W-1:0]                           fill,
	input  mbps_pkg::cfg_t                              cfg,
	output mbps_pkg::match_t                            result
);

	localparam int LEN_W = mbps_pkg::LEN_W;

	logic [LEN_W-1:0]       eff_len;
	logic [LEN_W-1:0]       len_m1;
	logic [PATTERN_MAX-1:0] lane_ok;

	// Clamp the programmed length into one to the window depth.
	always_comb begin
		if (cfg.pattern_length == '0) begin
			eff_len = LEN_W'(1);
		end else if (cfg.pattern_length > LEN_W'(PATTERN_MAX)) begin
			eff_len = LEN_W'(PATTERN_MAX);
		end else begin
			eff_len = cfg.pattern_length;
		end
	end

	assign len_m1 = eff_len - LEN_W'(1);

	// Pattern byte i lines up with window entry len-1-i. Lanes past the
	// length and wildcard lanes always pass.
	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_lane
		logic [LEN_W-1:0]            tap;
		logic [IDX_W-1:0]            tap_idx;
		logic [mbps_pkg::BYTE_W-1:0] pat_byte;

		assign tap      = len_m1 - LEN_W'(i);
		assign tap_idx  = tap[IDX_W-1:0];
		assign pat_byte = cfg.pattern[i*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W];
		assign lane_ok[i] = (LEN_W'(i) >= eff_len) || !cfg.care_mask[i] ||
			(window[tap_idx] == pat_byte);
	end

	// A hit needs enough valid bytes in the current region.
	assign result.hit    = (LEN_W'(fill) >= eff_len) && (&lane_ok);
	assign result.len_m1 = len_m1;

endmodule

[hw/rtl/masked_byte_pattern_scanner_core.sv]
// Top level of the masked byte pattern scanner: input stage, result register
// and match accounting. Depends on mbps_pkg, mbps_cfg_regs, mbps_window and
// mbps_match.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid, in_stall) carries one scanned byte per
// transaction with its address and a restart flag that opens a new region.
// The output channel (out_valid, out_stall) carries one transaction per
// match: the address of the first matched byte, the running match number
// and scan_done on the match that ends the scan.
// The configuration channel (cfg_valid, cfg_ready) writes one register per
// transaction; cfg_ready is always high. Write only while the block is idle.
// Throughput is one byte per cycle while in_stall is low. The window shifts
// when a byte is taken and the masked compare runs in the cycle after. The
// byte's address waits in the input stage register until the result register
// is free; a match then loads the result register, which out_stall can hold.
// When out_stall holds a result, one more byte can still be taken if the input
// stage is empty; after that in_stall rises until the result is taken.
// Reset clears the window fill, the match count, the stop flag, both stage
// valids and the configuration registers to their reset values. Once the
// scan has ended, bytes are still taken but give no result until the next reset.
module masked_byte_pattern_scanner_core #(
	parameter int PATTERN_MAX = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write channel.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Byte input channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mbps_pkg::BYTE_W-1:0]          data_byte,
	input  logic [mbps_pkg::ADDR_W-1:0]          byte_address,
	input  logic                                 restart,
	// Match output channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mbps_pkg::ADDR_W-1:0]          match_address,
	output logic [mbps_pkg::COUNT_W-1:0]         match_number,
	output logic                                 scan_done
);

	localparam int FILL_W  = $clog2(PATTERN_MAX + 1);
	localparam int ADDR_W  = mbps_pkg::ADDR_W;
	localparam int COUNT_W = mbps_pkg::COUNT_W;

	mbps_pkg::cfg_t                               cfg;
	mbps_pkg::match_t                             match;
	logic [PATTERN_MAX-1:0][mbps_pkg::BYTE_W-1:0] window;
	logic [FILL_W-1:0]                            fill;

	logic               valid_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic               accept;
	logic               s1_adv;
	logic               produce;
	logic               out_free;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_next;
	logic               stop_next;
	logic               stopped_q;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [COUNT_W-1:0] out_number_q;
	logic               out_done_q;

	mbps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbps_window #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (accept),
		.restart   (restart),
		.data_byte (data_byte),
		.window    (window),
		.fill      (fill)
	);

	mbps_match #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_match (
		.window (window),
		.fill   (fill),
		.cfg    (cfg),
		.result (match)
	);

	// Handshake: the input stage moves on whenever the result register is
	// empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;
	assign produce  = s1_adv && match.hit && !stopped_q;

	// Input stage: the byte itself already sits in the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= byte_address;
		end
	end

	// Saturating match count and the stop decision for this match.
	assign count_next = (count_q == '1) ? count_q : count_q + COUNT_W'(1);
	assign stop_next  = cfg.first_match_only ||
		((cfg.result_limit != '0) && (count_next >= cfg.result_limit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			stopped_q <= 1'b0;
		end else if (produce) begin
			count_q   <= count_next;
			stopped_q <= stop_next;
		end
	end

	// Result register: a new result loads it, a held result stays while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= produce || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			out_addr_q   <= addr_s1 - ADDR_W'(match.len_m1);
			out_number_q <= count_next;
			out_done_q   <= stop_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_address = out_addr_q;
	assign match_number  = out_number_q;
	assign scan_done     = out_done_q;

`ifndef ASSERT_OFF
	// The fill count never passes the window depth.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= FILL_W'(PATTERN_MAX))
		else $error("window fill above depth");

	// Once the scan has ended it stays ended until reset.
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stop flag cleared without reset");

	// A byte held in the input stage is neither lost nor overwritten.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(addr_s1)))
		else $error("input stage item lost");

	// The match count only ever steps up by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (count_q == $past(count_q) + COUNT_W'(1)))
		else $error("match count jumped");
`endif

endmodule

[tb/sv/masked_byte_pattern_scanner_core_tb.sv]
// Self-checking testbench for the masked byte pattern scanner core.
// Depends on mbps_pkg and masked_byte_pattern_scanner_core; predicts every match internally.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_core_tb;

	localparam int BYTE_W        = mbps_pkg::BYTE_W;
	localparam int ADDR_W        = mbps_pkg::ADDR_W;
	localparam int COUNT_W       = mbps_pkg::COUNT_W;
	localparam int LEN_W         = mbps_pkg::LEN_W;
	localparam int CFG_IDX_W     = mbps_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W    = mbps_pkg::CFG_DATA_W;
	localparam int PATTERN_BYTES = mbps_pkg::PATTERN_BYTES;
	localparam int PATTERN_W     = mbps_pkg::PATTERN_W;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PATTERN_MAX   = 16;
	localparam int PHASE_ITEMS   = 165;
	localparam int EXP_DEPTH     = 16;
	localparam int EXP_IDX_W     = $clog2(EXP_DEPTH);

	typedef struct {
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] number;
		logic               done;
	} match_rec_t;

	typedef enum int {
		STOP_AT_LIMIT,
		STOP_LIMIT_LOWERED,
		STOP_FIRST_MATCH
	} stop_mode_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [BYTE_W-1:0]     data_byte    = '0;
	logic [ADDR_W-1:0]     byte_address = '0;
	logic                  restart      = 1'b0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [ADDR_W-1:0]     match_address;
	logic [COUNT_W-1:0]    match_number;
	logic                  scan_done;

	// Predicted scanner state and register copies.
	logic [BYTE_W-1:0]        recent_bytes [PATTERN_MAX];
	int unsigned              window_count   = 0;
	logic [COUNT_W-1:0]       hit_count      = '0;
	logic                     scan_stopped   = 1'b0;
	logic [PATTERN_W-1:0]     sig_pattern    = '0;
	logic [PATTERN_BYTES-1:0] sig_care       = mbps_pkg::CARE_RESET;
	logic [LEN_W-1:0]         sig_length     = mbps_pkg::LEN_RESET;
	logic [COUNT_W-1:0]       sig_limit      = '0;
	logic                     sig_first_only = 1'b0;

	// Predicted matches waiting for their result, kept in a small ring.
	match_rec_t               expected_matches [EXP_DEPTH];
	logic [EXP_IDX_W-1:0]     exp_wr         = '0;
	logic [EXP_IDX_W-1:0]     exp_rd         = '0;
	match_rec_t               head_match;
	int unsigned              mismatch_count = 0;
	int unsigned              cycle_count    = 0;
	int unsigned              items_sent     = 0;
	int unsigned              send_idle_pct  = 0;
	int unsigned              stall_pct      = 0;
	logic [ADDR_W-1:0]        region_addr    = '0;

	masked_byte_pattern_scanner_core #(
		.PATTERN_MAX(PATTERN_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.byte_address(byte_address),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.match_address(match_address),
		.match_number(match_number),
		.scan_done(scan_done)
	);

	always #CLK_HALF clk = ~clk;

	// Random backpressure on the match channel.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Compare each accepted match transaction with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (exp_wr == exp_rd) begin
				$display("%0t: unexpected match: address %h number %0d done %b",
					$time, match_address, match_number, scan_done);
				mismatch_count++;
			end else begin
				head_match = expected_matches[exp_rd];
				exp_rd++;
				if (match_address !== head_match.addr) begin
					$display("%0t: match_address expected %h actual %h",
						$time, head_match.addr, match_address);
					mismatch_count++;
				end
				if (match_number !== head_match.number) begin
					$display("%0t: match_number expected %0d actual %0d",
						$time, head_match.number, match_number);
					mismatch_count++;
				end
				if (scan_done !== head_match.done) begin
					$display("%0t: scan_done expected %b actual %b",
						$time, head_match.done, scan_done);
					mismatch_count++;
				end
			end
		end
	end

	// Pattern length actually compared, after clamping to the legal range.
	function automatic int unsigned active_length();
		if (sig_length == 0)
			return 1;
		if (sig_length > PATTERN_MAX)
			return PATTERN_MAX;
		return sig_length;
	endfunction

	// Advance the predicted window by one byte; returns 1 when a match results.
	function automatic bit scan_byte(input logic [BYTE_W-1:0] value,
			input logic [ADDR_W-1:0] addr, input logic new_region, output match_rec_t m);
		int unsigned len;
		bit hit;
		if (scan_stopped)
			return 0;
		if (new_region)
			window_count = 0;
		for (int i = PATTERN_MAX - 1; i > 0; i--)
			recent_bytes[i] = recent_bytes[i - 1];
		recent_bytes[0] = value;
		if (window_count < PATTERN_MAX)
			window_count++;
		len = active_length();
		if (window_count < len)
			return 0;
		hit = 1'b1;
		for (int i = 0; i < len; i++) begin
			if (sig_care[i] && recent_bytes[len - 1 - i] != sig_pattern[i*BYTE_W +: BYTE_W])
				hit = 1'b0;
		end
		if (!hit)
			return 0;
		if (hit_count != '1)
			hit_count++;
		if (sig_first_only || (sig_limit != 0 && hit_count >= sig_limit))
			scan_stopped = 1'b1;
		m.addr   = addr - ADDR_W'(len - 1);
		m.number = hit_count;
		m.done   = scan_stopped;
		return 1;
	endfunction

	// Offer one byte transaction after a random gap and record its prediction.
	task automatic send_byte(input logic [BYTE_W-1:0] value, input logic [ADDR_W-1:0] addr,
			input logic new_region);
		match_rec_t m;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		data_byte    <= value;
		byte_address <= addr;
		restart      <= new_region;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (scan_byte(value, addr, new_region, m)) begin
			expected_matches[exp_wr] = m;
			exp_wr++;
		end
	endtask

	// Start address for a new region, often close to either end of the space.
	function automatic logic [ADDR_W-1:0] fresh_region();
		case ($urandom_range(3))
			0: return {ADDR_W{1'b1}} - ADDR_W'($urandom_range(20));
			1: return ADDR_W'($urandom_range(20));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Send a byte at the next address of the current region.
	task automatic feed(input logic [BYTE_W-1:0] value, input logic new_region);
		if (new_region)
			region_addr = fresh_region();
		send_byte(value, region_addr, new_region);
		region_addr++;
	endtask

	// Drop valid and hold off until every predicted match has been taken.
	task automatic wait_for_matches();
		in_valid <= 1'b0;
		while (exp_wr != exp_rd)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write transaction; the prediction follows on acceptance.
	task automatic write_reg(input mbps_pkg::cfg_reg_t idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			mbps_pkg::REG_PATTERN_LOW:  sig_pattern[CFG_DATA_W-1:0] = value;
			mbps_pkg::REG_PATTERN_HIGH: sig_pattern[PATTERN_W-1:CFG_DATA_W] = value;
			mbps_pkg::REG_CARE_MASK:    sig_care = value[PATTERN_BYTES-1:0];
			mbps_pkg::REG_PATTERN_LEN:  sig_length = value[LEN_W-1:0];
			mbps_pkg::REG_RESULT_LIMIT: sig_limit = value[COUNT_W-1:0];
			mbps_pkg::REG_FIRST_ONLY:   sig_first_only = value[0];
			default: ;
		endcase
	endtask

	// Write the whole register set; only called while the scanner is idle.
	task automatic load_pattern(input logic [CFG_DATA_W-1:0] low_word,
			input logic [CFG_DATA_W-1:0] high_word, input logic [PATTERN_BYTES-1:0] care,
			input logic [LEN_W-1:0] len, input logic [COUNT_W-1:0] limit,
			input logic first_only);
		write_reg(mbps_pkg::REG_PATTERN_LOW, low_word);
		write_reg(mbps_pkg::REG_PATTERN_HIGH, high_word);
		write_reg(mbps_pkg::REG_CARE_MASK, CFG_DATA_W'(care));
		write_reg(mbps_pkg::REG_PATTERN_LEN, CFG_DATA_W'(len));
		write_reg(mbps_pkg::REG_RESULT_LIMIT, CFG_DATA_W'(limit));
		write_reg(mbps_pkg::REG_FIRST_ONLY, CFG_DATA_W'(first_only));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pattern_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// A pattern occurrence, sometimes with one corrupted byte or a region break inside.
	task automatic send_occurrence();
		int unsigned len;
		int unsigned cut;
		int unsigned bad;
		logic [BYTE_W-1:0] value;
		len = active_length();
		cut = ($urandom_range(99) < 12) ? $urandom_range(len - 1) : len;
		bad = ($urandom_range(99) < 12) ? $urandom_range(len - 1) : len;
		for (int i = 0; i < len; i++) begin
			value = sig_care[i] ? sig_pattern[i*BYTE_W +: BYTE_W] : BYTE_W'($urandom);
			if (i == bad)
				value ^= BYTE_W'(1 << $urandom_range(BYTE_W - 1));
			feed(value, (i == 0 && $urandom_range(9) == 0) || i == cut);
		end
	endtask

	// A few filler bytes, half of them taken from the pattern itself.
	task automatic send_noise();
		int unsigned n;
		logic [BYTE_W-1:0] value;
		n = $urandom_range(1, 4);
		repeat (n) begin
			if ($urandom_range(1))
				value = sig_pattern[$urandom_range(PATTERN_BYTES - 1)*BYTE_W +: BYTE_W];
			else
				value = BYTE_W'($urandom);
			feed(value, $urandom_range(19) == 0);
		end
	endtask

	task automatic scan_stream(input int unsigned n);
		int unsigned start;
		start = items_sent;
		while (items_sent - start < n) begin
			if ($urandom_range(99) < 60)
				send_occurrence();
			else
				send_noise();
			// Now and then let the pipeline run completely dry.
			if ($urandom_range(199) == 0)
				wait_for_matches();
		end
	endtask

	// Reset register values: a single zero byte is the whole pattern.
	task automatic test_reset_config();
		send_byte(8'h00, '0, 1'b1);
		send_byte(8'hFF, '1, 1'b0);
		send_byte(8'h00, '1, 1'b0);
		wait_for_matches();
	endtask

	// Over-long length clamps to the full window; the match start wraps below zero.
	task automatic test_long_pattern_wrap();
		logic [ADDR_W-1:0] base;
		logic [BYTE_W-1:0] value;
		load_pattern(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 16'hBFFF, 5'd31,
			'1, 1'b0);
		base = {ADDR_W{1'b1}} - 4;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			value = sig_pattern[i*BYTE_W +: BYTE_W];
			if (!sig_care[i])
				value = ~value;
			send_byte(value, base + ADDR_W'(i), i == 0);
		end
		wait_for_matches();
	endtask

	// Zero length acts as one byte; a restart inside a pattern breaks the match.
	task automatic test_short_length_restart();
		load_pattern(64'h34AB, '0, '1, 5'd0, '0, 1'b0);
		feed(8'hAB, 1'b1);
		wait_for_matches();
		load_pattern(64'h34AB, '0, '1, 5'd2, '0, 1'b0);
		feed(8'hAB, 1'b0);
		feed(8'h34, 1'b1);
		feed(8'hAB, 1'b0);
		feed(8'h34, 1'b0);
		wait_for_matches();
	endtask

	// Random patterns and streams under each idling mix.
	task automatic test_random_scan();
		logic [LEN_W-1:0]         len;
		logic [PATTERN_BYTES-1:0] care;
		logic [COUNT_W-1:0]       limit;
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 81; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 81; end
				default: begin send_idle_pct = 29; stall_pct = 29; end
			endcase
			case ($urandom_range(9))
				0: len = '0;
				1: len = LEN_W'(PATTERN_MAX);
				2: len = LEN_W'($urandom_range(17, 31));
				default: len = LEN_W'($urandom_range(1, 6));
			endcase
			case ($urandom_range(7))
				0: care = '0;
				1: care = '1;
				default: care = PATTERN_BYTES'($urandom) | PATTERN_BYTES'($urandom);
			endcase
			case ($urandom_range(2))
				0: limit = '0;
				1: limit = '1;
				default: limit = hit_count + 100000 + $urandom_range(1000);
			endcase
			load_pattern(pattern_word(), pattern_word(), care, len, limit, 1'b0);
			scan_stream(PHASE_ITEMS);
			wait_for_matches();
		end
	endtask

	// End the scan one way or another; every byte after that must be ignored.
	task automatic test_scan_stop();
		stop_mode_t mode;
		logic [COUNT_W-1:0] limit;
		logic first_only;
		mode = stop_mode_t'($urandom_range(2));
		send_idle_pct = 29;
		stall_pct     = 29;
		first_only    = 1'b0;
		case (mode)
			STOP_AT_LIMIT: limit = hit_count + $urandom_range(1, 4);
			STOP_LIMIT_LOWERED: limit = (hit_count >= 2) ? $urandom_range(1, hit_count - 1) : 1;
			default: begin
				limit      = '0;
				first_only = 1'b1;
			end
		endcase
		load_pattern(pattern_word(), pattern_word(), '1, LEN_W'($urandom_range(1, 3)),
			limit, first_only);
		scan_stream(80);
		wait_for_matches();
	endtask

	initial begin
		for (int i = 0; i < PATTERN_MAX; i++)
			recent_bytes[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_long_pattern_wrap();
		test_short_length_restart();
		test_random_scan();
		test_scan_stop();
		wait_for_matches();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[masked_byte_pattern_scanner_core.f]
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cfg_regs.sv
hw/rtl/mbps_window.sv
hw/rtl/mbps_match.sv
hw/rtl/masked_byte_pattern_scanner_core.sv
tb/sv/masked_byte_pattern_scanner_core_tb.sv
